// ----- sv/interval_capacity_admission_core_assert.svh -----
// Assertion macros for the interval capacity admission core.
// Expects signals named clk and rst_n in the including module.
`ifndef INTERVAL_CAPACITY_ADMISSION_CORE_ASSERT_SVH
`define INTERVAL_CAPACITY_ADMISSION_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interval capacity admission check failed");

// The consequent must hold in the cycle after the antecedent.
`define ICA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interval capacity admission check failed");

`endif

// ----- sv/ica_pkg.sv -----
// Shared constants and types for the interval capacity admission core.
// No dependencies.
`default_nettype none
package ica_pkg;

  localparam int NUM_SLOTS = 2048;
  localparam int SLOT_AW   = $clog2(NUM_SLOTS);
  localparam int SLOT_W    = 11;
  localparam int POS_W     = 17;
  localparam int AMT_W     = 16;
  localparam int SUM_W     = 40;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [CFG_AW-3:0] REG_SLOT_CAPACITY = '0;
  localparam logic [AMT_W-1:0]  CAPACITY_RESET    = '1;

  typedef struct packed {
    logic [SLOT_W-1:0] first_slot;
    logic [SLOT_W-1:0] end_slot;
    logic [AMT_W-1:0]  wanted;
  } req_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    logic [AMT_W-1:0] grant;
  } rsp_t;

endpackage
`default_nettype wire

// ----- sv/interval_capacity_admission_core.sv -----
// Top level of the interval capacity admission core: handshakes, register port, running total.
// Depends on ica_pkg, ica_span_engine and interval_capacity_admission_core_assert.svh.
//
//   Channel  Direction  Handshake           Payload
//   in_      request    in_valid/in_stall   start_slot, end_slot, wanted_amount
//   out_     result     out_valid/out_stall granted_amount, total_granted
//   cfg_     register   APB, pready high    slot_capacity at byte address 0
//
// A request's span is swept twice through the single read and write port of the slot load
// memory: once to find the peak load and once more to add the grant. An empty span skips both.
// After reset a clearing pass writes zero to all 2048 slots, one per cycle, with in_stall high.
// A finished result waits in the output register while the next request is taken.
`default_nettype none
module interval_capacity_admission_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [ica_pkg::SLOT_W-1:0] in_start_slot,
  input  wire logic [ica_pkg::SLOT_W-1:0] in_end_slot,
  input  wire logic [ica_pkg::AMT_W-1:0]  in_wanted_amount,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [ica_pkg::AMT_W-1:0]       out_granted_amount,
  output logic [ica_pkg::SUM_W-1:0]       out_total_granted,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [ica_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [ica_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ica_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  localparam logic [ica_pkg::SUM_W-1:0] SUM_MAX = '1;

  ica_pkg::req_t             req;
  ica_pkg::rsp_t             eng_rsp;
  logic                      start;
  logic                      ack;
  logic                      cfg_write;
  logic                      cfg_hit;
  logic [ica_pkg::AMT_W-1:0] capacity_r;
  logic [ica_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [ica_pkg::SUM_W:0]   sum_wide;
  logic                      out_valid_r;
  logic [ica_pkg::AMT_W-1:0] out_grant_r;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[ica_pkg::CFG_AW-1:2] == ica_pkg::REG_SLOT_CAPACITY);
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? ica_pkg::CFG_DW'(capacity_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= ica_pkg::CAPACITY_RESET;
    end else if (cfg_write && cfg_hit) begin
      capacity_r <= cfg_pwdata[ica_pkg::AMT_W-1:0];
    end
  end

  assign in_stall       = !eng_rsp.idle;
  assign start          = in_valid && !in_stall;
  assign req.first_slot = in_start_slot;
  assign req.end_slot   = in_end_slot;
  assign req.wanted     = in_wanted_amount;

  ica_span_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (req),
    .capacity (capacity_r),
    .ack      (ack),
    .rsp      (eng_rsp)
  );

  assign ack      = eng_rsp.done && (!out_valid_r || !out_stall);
  assign sum_wide = {1'b0, sum_r} + (ica_pkg::SUM_W + 1)'(eng_rsp.grant);
  assign sum_nxt  = sum_wide[ica_pkg::SUM_W] ? SUM_MAX : sum_wide[ica_pkg::SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (ack) begin
      sum_r       <= sum_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      out_grant_r <= eng_rsp.grant;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted_amount = out_grant_r;
  assign out_total_granted  = sum_r;

`include "interval_capacity_admission_core_assert.svh"

  `ICA_ASSERT_NEXT(a_accept_leaves_idle, start, !eng_rsp.idle)
  `ICA_ASSERT_SAME(a_grant_within_capacity, eng_rsp.done, eng_rsp.grant <= capacity_r)
  `ICA_ASSERT_SAME(a_total_never_falls, ack, sum_nxt >= sum_r)
  `ICA_ASSERT_SAME(a_result_from_engine, $rose(out_valid_r), $past(ack))

endmodule
`default_nettype wire

// ----- sv/ica_span_engine.sv -----
// Span engine: slot load memory, clearing pass, peak scan and grant write-back.
// Depends on ica_pkg.
`default_nettype none
module ica_span_engine (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire ica_pkg::req_t             req,
  input  wire logic [ica_pkg::AMT_W-1:0] capacity,
  input  wire logic                      ack,
  output ica_pkg::rsp_t                  rsp
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [ica_pkg::POS_W-1:0] LAST_SLOT  = ica_pkg::POS_W'(ica_pkg::NUM_SLOTS - 1);
  localparam logic [ica_pkg::POS_W-1:0] SLOT_COUNT = ica_pkg::POS_W'(ica_pkg::NUM_SLOTS);

  logic [ica_pkg::AMT_W-1:0] mem [ica_pkg::NUM_SLOTS];

  logic [2:0]                  state_r, state_nxt;
  logic [ica_pkg::POS_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic [ica_pkg::POS_W-1:0]   first_r, first_nxt;
  logic [ica_pkg::POS_W-1:0]   last_r, last_nxt;
  logic [ica_pkg::AMT_W-1:0]   wanted_r, wanted_nxt;
  logic [ica_pkg::AMT_W-1:0]   peak_r, peak_nxt;
  logic [ica_pkg::AMT_W-1:0]   grant_r, grant_nxt;
  logic [ica_pkg::SLOT_AW-1:0] wr_addr_r, wr_addr_nxt;
  logic [ica_pkg::AMT_W-1:0]   rd_data_r;

  logic                        mem_we;
  logic [ica_pkg::SLOT_AW-1:0] mem_waddr;
  logic [ica_pkg::AMT_W-1:0]   mem_wdata;
  logic                        mem_re;
  logic [ica_pkg::POS_W-1:0]   req_first;
  logic [ica_pkg::POS_W-1:0]   req_end;
  logic [ica_pkg::POS_W-1:0]   req_last;
  logic [ica_pkg::AMT_W-1:0]   room;

  assign req_first = ica_pkg::POS_W'(req.first_slot);
  assign req_end   = ica_pkg::POS_W'(req.end_slot);
  assign req_last  = (req_end > SLOT_COUNT) ? SLOT_COUNT : req_end;
  assign room      = (capacity > peak_r) ? (capacity - peak_r) : '0;

  always_comb begin
    state_nxt   = state_r;
    rd_ptr_nxt  = rd_ptr_r;
    rd_pend_nxt = 1'b0;
    first_nxt   = first_r;
    last_nxt    = last_r;
    wanted_nxt  = wanted_r;
    peak_nxt    = peak_r;
    grant_nxt   = grant_r;
    wr_addr_nxt = wr_addr_r;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr_r;
    mem_wdata   = rd_data_r + grant_r;
    mem_re      = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        mem_we     = 1'b1;
        mem_waddr  = rd_ptr_r[ica_pkg::SLOT_AW-1:0];
        mem_wdata  = '0;
        rd_ptr_nxt = ica_pkg::POS_W'(rd_ptr_r + 1'b1);
        if (rd_ptr_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          first_nxt  = req_first;
          last_nxt   = req_last;
          wanted_nxt = req.wanted;
          peak_nxt   = '0;
          rd_ptr_nxt = req_first;
          state_nxt  = (req_first < req_last) ? ST_SCAN : ST_CALC;
        end
      end
      ST_SCAN: begin
        if (rd_ptr_r < last_r) begin
          mem_re      = 1'b1;
          rd_ptr_nxt  = ica_pkg::POS_W'(rd_ptr_r + 1'b1);
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r && (rd_data_r > peak_r)) begin
          peak_nxt = rd_data_r;
        end
        if ((rd_ptr_r >= last_r) && !rd_pend_r) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        grant_nxt  = (wanted_r < room) ? wanted_r : room;
        rd_ptr_nxt = first_r;
        state_nxt  = (first_r < last_r) ? ST_ADD : ST_DONE;
      end
      ST_ADD: begin
        if (rd_ptr_r < last_r) begin
          mem_re      = 1'b1;
          rd_ptr_nxt  = ica_pkg::POS_W'(rd_ptr_r + 1'b1);
          rd_pend_nxt = 1'b1;
          wr_addr_nxt = rd_ptr_r[ica_pkg::SLOT_AW-1:0];
        end
        if (rd_pend_r) begin
          mem_we = 1'b1;
        end
        if ((rd_ptr_r >= last_r) && !rd_pend_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      rd_ptr_r  <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    wanted_r  <= wanted_nxt;
    peak_r    <= peak_nxt;
    grant_r   <= grant_nxt;
    wr_addr_r <= wr_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_ptr_r[ica_pkg::SLOT_AW-1:0]];
    end
  end

  assign rsp.idle  = (state_r == ST_IDLE);
  assign rsp.done  = (state_r == ST_DONE);
  assign rsp.grant = grant_r;

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for interval_capacity_admission_core: directed and random requests
// against a slot load predictor, with random idling on both channels and APB register writes.
// Depends on ica_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ica_pkg::*;

  localparam logic [CFG_AW-3:0] REG_UNMAPPED  = 1'b1;
  localparam logic [SUM_W-1:0]  TOTAL_CEILING = '1;
  localparam int                LAST_SLOT     = 2047;

  typedef struct {
    logic [AMT_W-1:0] granted;
    logic [SUM_W-1:0] total;
  } admission_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [SLOT_W-1:0] in_start_slot;
  logic [SLOT_W-1:0] in_end_slot;
  logic [AMT_W-1:0]  in_wanted_amount;
  logic              out_valid;
  logic              out_stall;
  logic [AMT_W-1:0]  out_granted_amount;
  logic [SUM_W-1:0]  out_total_granted;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  logic [AMT_W-1:0] load_shadow [NUM_SLOTS];
  logic [SUM_W-1:0] total_shadow;
  logic [AMT_W-1:0] capacity_shadow;
  admission_t       pending_admissions [$];
  admission_t       oldest_admission;
  int               mismatch_count;
  bit               idling_on;

  interval_capacity_admission_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_start_slot      (in_start_slot),
    .in_end_slot        (in_end_slot),
    .in_wanted_amount   (in_wanted_amount),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_granted_amount (out_granted_amount),
    .out_total_granted  (out_total_granted),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  function automatic void admit_request(input logic [SLOT_W-1:0] first,
                                        input logic [SLOT_W-1:0] stop,
                                        input logic [AMT_W-1:0] wanted);
    logic [AMT_W-1:0] peak;
    logic [AMT_W-1:0] room;
    logic [AMT_W-1:0] grant;
    int               last;
    admission_t       result;
    peak = '0;
    last = (stop > NUM_SLOTS) ? NUM_SLOTS : int'(stop);
    for (int j = int'(first); j < last; j++) begin
      if (load_shadow[j] > peak) begin
        peak = load_shadow[j];
      end
    end
    room = (capacity_shadow > peak) ? capacity_shadow - peak : '0;
    grant = (wanted < room) ? wanted : room;
    for (int j = int'(first); j < last; j++) begin
      load_shadow[j] = load_shadow[j] + grant;
    end
    if (total_shadow > TOTAL_CEILING - SUM_W'(grant)) begin
      total_shadow = TOTAL_CEILING;
    end else begin
      total_shadow = total_shadow + SUM_W'(grant);
    end
    result.granted = grant;
    result.total = total_shadow;
    pending_admissions.insert(pending_admissions.size(), result);
  endfunction

  task automatic send_request(input int first, input int stop, input int wanted);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_start_slot = SLOT_W'(first);
    in_end_slot = SLOT_W'(stop);
    in_wanted_amount = AMT_W'(wanted);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    admit_request(in_start_slot, in_end_slot, in_wanted_amount);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_admissions.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_AW-3:0] index, input logic [CFG_DW-1:0] data);
    drain_results();
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {index, 2'b00};
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if (index == REG_SLOT_CAPACITY) begin
      capacity_shadow = data[AMT_W-1:0];
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic check_capacity_readback();
    logic [CFG_DW-1:0] readback;
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b0;
    cfg_penable = 1'b0;
    cfg_paddr = {REG_SLOT_CAPACITY, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (readback[AMT_W-1:0] !== capacity_shadow) begin
      report_mismatch("slot_capacity readback", 64'(readback[AMT_W-1:0]),
                      64'(capacity_shadow));
    end
  endtask

  task automatic set_capacity(input int capacity);
    write_register(REG_SLOT_CAPACITY, {16'($urandom()), AMT_W'(capacity)});
    check_capacity_readback();
  endtask

  task automatic test_reset_state();
    check_capacity_readback();
    if (capacity_shadow !== CAPACITY_RESET) begin
      report_mismatch("slot_capacity reset value", 64'(capacity_shadow), 64'(CAPACITY_RESET));
    end
  endtask

  task automatic test_span_extremes();
    send_request(0, LAST_SLOT, 1);
    send_request(LAST_SLOT - 1, LAST_SLOT, 65535);
    send_request(LAST_SLOT - 1, LAST_SLOT, 5);
    send_request(0, 1, 0);
    send_request(5, 5, 700);
    send_request(LAST_SLOT, 0, 65535);
    send_request(100, 50, 3);
    send_request(LAST_SLOT, LAST_SLOT, 9);
    send_request(10, 20, 300);
    send_request(15, 25, 400);
    send_request(1365, 1706, 682);
  endtask

  task automatic test_capacity_limits();
    set_capacity(200);
    send_request(12, 18, 50);
    send_request(1000, 1010, 500);
    set_capacity(0);
    send_request(1500, 1510, 10);
    send_request(3, 3, 10);
    set_capacity(1);
    send_request(1200, 1201, 9);
    send_request(1800, 1900, 9);
  endtask

  task automatic test_unmapped_register();
    write_register(REG_UNMAPPED, $urandom());
    check_capacity_readback();
    send_request(30, 30, 10);
    set_capacity(65535);
    send_request(40, 44, 1234);
  endtask

  task automatic test_random_phase(input int capacity, input int count, input bit with_idling);
    int base;
    int kind;
    int first;
    int stop;
    int wanted;
    set_capacity(capacity);
    idling_on = with_idling;
    base = $urandom_range(0, LAST_SLOT - 96);
    repeat (count) begin
      kind = $urandom_range(0, 9);
      first = $urandom_range(0, LAST_SLOT);
      if (kind == 0) begin
        stop = $urandom_range(0, first);
      end else if (kind <= 2) begin
        stop = first + $urandom_range(1, 16);
      end else if (kind == 3) begin
        stop = first + $urandom_range(17, 512);
      end else begin
        first = base + $urandom_range(0, 63);
        stop = first + $urandom_range(1, 24);
      end
      if (stop > LAST_SLOT) begin
        stop = LAST_SLOT;
      end
      wanted = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2000);
      send_request(first, stop, wanted);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_admissions.size() == 0) begin
        report_mismatch("unexpected result, granted_amount", 64'(out_granted_amount), '0);
      end else begin
        oldest_admission = pending_admissions.pop_front();
        if (out_granted_amount !== oldest_admission.granted) begin
          report_mismatch("granted_amount", 64'(out_granted_amount),
                          64'(oldest_admission.granted));
        end
        if (out_total_granted !== oldest_admission.total) begin
          report_mismatch("total_granted", 64'(out_total_granted),
                          64'(oldest_admission.total));
        end
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_slot = '0;
    in_end_slot = '0;
    in_wanted_amount = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatch_count = 0;
    idling_on = 1'b1;
    foreach (load_shadow[j]) load_shadow[j] = '0;
    total_shadow = '0;
    capacity_shadow = CAPACITY_RESET;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    do @(posedge clk); while (in_stall);

    test_reset_state();
    test_span_extremes();
    test_capacity_limits();
    test_unmapped_register();
    test_random_phase($urandom_range(1000, 30000), 31, 1'b1);
    test_random_phase(65535, 31, 1'b1);
    test_random_phase(1, 31, 1'b1);
    test_random_phase($urandom_range(1, 65535), 31, 1'b0);

    drain_results();
    repeat (4200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
